// ===== rtl/mer_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mer_pkg
// Shared sizes, request codes and the command/status bundles that pass
// between the midpoint ellipse controller and its datapath.
// ----------------------------------------------------------------------------
package mer_pkg;

  // field sizes
  localparam int RADIUS_BITS = 10;
  localparam int COORD_BITS  = 11;
  localparam int DEC_W       = 48;
  localparam int OUT_W       = COORD_BITS + 2;

  // offsets: x never goes negative, y may reach -1
  localparam int X_W = RADIUS_BITS + 1;
  localparam int Y_W = RADIUS_BITS + 2;

  // squared radius and the incremental terms 2*ry^2*x, 2*rx^2*y
  localparam int SQ_W = 2 * RADIUS_BITS;
  localparam int PW   = 3 * RADIUS_BITS + 4;

  // shared multiplier operands and product
  localparam int MA_W = 2 * RADIUS_BITS;
  localparam int MB_W = 2 * RADIUS_BITS + 4;
  localparam int PR_W = MA_W + MB_W;

  // exact starting numerators (signed)
  localparam int NUM_W = 4 * RADIUS_BITS + 7;

  // request mode codes
  localparam logic MODE_START = 1'b0;
  localparam logic MODE_STEP  = 1'b1;

  // operand pair for the shared multiplier
  typedef enum logic [3:0] {
    MUL_NONE,
    MUL_RXRX,
    MUL_RYRY,
    MUL_RX2RY,
    MUL_TXTX,
    MUL_RY2P,
    MUL_YMYM,
    MUL_RX2P,
    MUL_RX2RY2
  } mul_op_t;

  // what the datapath does with the registered product
  typedef enum logic [2:0] {
    WB_NONE,
    WB_RX2,
    WB_RY2,
    WB_INIT1,
    WB_ACC_SET,
    WB_ACC_ADD4,
    WB_ACC_SUB4,
    WB_QTR
  } wb_op_t;

  typedef struct packed {
    logic    load;
    logic    step;
    mul_op_t mul_op;
    wb_op_t  wb_op;
  } cmd_t;

  typedef struct packed {
    logic last;
    logic enter_r2;
  } status_t;

endpackage

// ===== rtl/mer_datapath.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mer_datapath
// Ellipse state, incremental decision update, one shared multiplier for the
// region start terms, and the result register.
// ----------------------------------------------------------------------------
module mer_datapath (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic [mer_pkg::COORD_BITS-1:0]       in_center_x,
  input  logic [mer_pkg::COORD_BITS-1:0]       in_center_y,
  input  logic [mer_pkg::RADIUS_BITS-1:0]      in_radius_x,
  input  logic [mer_pkg::RADIUS_BITS-1:0]      in_radius_y,
  input  mer_pkg::cmd_t                        cmd,
  output mer_pkg::status_t                     status,
  output logic signed [mer_pkg::OUT_W-1:0]     out_px_right,
  output logic signed [mer_pkg::OUT_W-1:0]     out_px_left,
  output logic signed [mer_pkg::OUT_W-1:0]     out_py_below,
  output logic signed [mer_pkg::OUT_W-1:0]     out_py_above,
  output logic                                 out_last_point
);
  import mer_pkg::*;

  // held request fields
  logic [COORD_BITS-1:0]  cx_r, cy_r;
  logic [RADIUS_BITS-1:0] rx_r, ry_r;
  logic                   zero_rad_r;
  logic [SQ_W-1:0]        rx2_r, ry2_r;

  // walk state
  logic [X_W-1:0]         x_r;
  logic signed [Y_W-1:0]  y_r;
  logic signed [PW-1:0]   px_r, py_r;
  logic [DEC_W-1:0]       dec_r;
  logic                   region2_r;

  // multiplier and start-term accumulator
  logic [PR_W-1:0]        prod_r;
  logic signed [NUM_W-1:0] acc_r;

  // result register
  logic signed [OUT_W-1:0] px_right_r, px_left_r, py_below_r, py_above_r;
  logic                    last_r;

  // step update
  logic signed [PW-1:0]   two_rx2, two_ry2, px_inc, py_dec, px_new, py_new;
  logic                   dec_neg, dec_pos, move_x, move_y;
  logic [X_W-1:0]         x_new;
  logic signed [Y_W-1:0]  y_new;
  logic [DEC_W-1:0]       dec_new, add_x, sub_y, add_k;
  logic                   enter_r2, last;

  assign two_rx2 = PW'({rx2_r, 1'b0});
  assign two_ry2 = PW'({ry2_r, 1'b0});
  assign px_inc  = px_r + two_ry2;
  assign py_dec  = py_r - two_rx2;
  assign dec_neg = dec_r[DEC_W-1];
  assign dec_pos = !dec_neg && (|dec_r);

  // region one always moves in x; region two always moves in y
  assign move_x = region2_r ? !dec_pos : 1'b1;
  assign move_y = region2_r ? 1'b1 : !dec_neg;

  assign x_new  = move_x ? x_r + X_W'(1) : x_r;
  assign y_new  = move_y ? y_r - Y_W'(1) : y_r;
  assign px_new = move_x ? px_inc : px_r;
  assign py_new = move_y ? py_dec : py_r;

  assign add_x   = move_x ? DEC_W'(px_new) : '0;
  assign sub_y   = move_y ? DEC_W'(py_new) : '0;
  assign add_k   = region2_r ? DEC_W'(rx2_r) : DEC_W'(ry2_r);
  assign dec_new = dec_r + add_x - sub_y + add_k;

  // region one ends once 2*ry^2*x passes 2*rx^2*y
  assign enter_r2 = !zero_rad_r && !region2_r && (px_new > py_new);
  assign last     = zero_rad_r ||
                    ((region2_r || enter_r2) && y_new[Y_W-1]);

  assign status.last     = last;
  assign status.enter_r2 = enter_r2;

  // multiplier operand select
  logic [X_W:0]          tx;
  logic signed [Y_W-1:0] ym;
  logic [Y_W-1:0]        ym_mag;
  logic [MA_W-1:0]       mul_a;
  logic [MB_W-1:0]       mul_b;

  assign tx     = {x_r, 1'b1};
  assign ym     = y_r - Y_W'(1);
  assign ym_mag = ym[Y_W-1] ? Y_W'(-ym) : Y_W'(ym);

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (cmd.mul_op)
      MUL_RXRX: begin
        mul_a = MA_W'(rx_r);
        mul_b = MB_W'(rx_r);
      end
      MUL_RYRY: begin
        mul_a = MA_W'(ry_r);
        mul_b = MB_W'(ry_r);
      end
      MUL_RX2RY: begin
        mul_a = MA_W'(rx2_r);
        mul_b = MB_W'(ry_r);
      end
      MUL_TXTX: begin
        mul_a = MA_W'(tx);
        mul_b = MB_W'(tx);
      end
      MUL_RY2P: begin
        mul_a = MA_W'(ry2_r);
        mul_b = MB_W'(prod_r);
      end
      MUL_YMYM: begin
        mul_a = MA_W'(ym_mag);
        mul_b = MB_W'(ym_mag);
      end
      MUL_RX2P: begin
        mul_a = MA_W'(rx2_r);
        mul_b = MB_W'(prod_r);
      end
      MUL_RX2RY2: begin
        mul_a = MA_W'(rx2_r);
        mul_b = MB_W'(ry2_r);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  // quarter of the start numerator, truncated toward zero
  logic signed [NUM_W-1:0] acc_round, acc_q;

  assign acc_round = acc_r + (acc_r[NUM_W-1] ? NUM_W'(3) : NUM_W'(0));
  assign acc_q     = acc_round >>> 2;

  // region flag
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      region2_r <= 1'b0;
    end else if (cmd.load) begin
      region2_r <= 1'b0;
    end else if (cmd.step && enter_r2) begin
      region2_r <= 1'b1;
    end
  end

  // held fields and walk state
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      cx_r       <= in_center_x;
      cy_r       <= in_center_y;
      rx_r       <= in_radius_x;
      ry_r       <= in_radius_y;
      zero_rad_r <= (in_radius_x == '0) && (in_radius_y == '0);
      x_r        <= '0;
      y_r        <= Y_W'(in_radius_y);
    end else if (cmd.step && !zero_rad_r) begin
      x_r   <= x_new;
      y_r   <= y_new;
      px_r  <= px_new;
      py_r  <= py_new;
      dec_r <= dec_new;
    end

    if (cmd.mul_op != MUL_NONE) begin
      prod_r <= PR_W'(mul_a) * PR_W'(mul_b);
    end

    case (cmd.wb_op)
      WB_RX2:      rx2_r <= prod_r[SQ_W-1:0];
      WB_RY2:      ry2_r <= prod_r[SQ_W-1:0];
      WB_INIT1: begin
        acc_r <= NUM_W'({ry2_r, 2'b00}) - NUM_W'({prod_r, 2'b00}) + NUM_W'(rx2_r);
        px_r  <= '0;
        py_r  <= PW'({prod_r, 1'b0});
      end
      WB_ACC_SET:  acc_r <= NUM_W'(prod_r);
      WB_ACC_ADD4: acc_r <= acc_r + NUM_W'({prod_r, 2'b00});
      WB_ACC_SUB4: acc_r <= acc_r - NUM_W'({prod_r, 2'b00});
      WB_QTR:      dec_r <= DEC_W'(acc_q);
      default: begin
      end
    endcase
  end

  // result register, loaded with the point current at the step
  always_ff @(posedge clk) begin
    if (cmd.step) begin
      px_right_r <= OUT_W'(cx_r) + OUT_W'(x_r);
      px_left_r  <= OUT_W'(cx_r) - OUT_W'(x_r);
      py_below_r <= OUT_W'(cy_r) + OUT_W'(y_r);
      py_above_r <= OUT_W'(cy_r) - OUT_W'(y_r);
      last_r     <= last;
    end
  end

  assign out_px_right   = px_right_r;
  assign out_px_left    = px_left_r;
  assign out_py_below   = py_below_r;
  assign out_py_above   = py_above_r;
  assign out_last_point = last_r;

endmodule

// ===== rtl/mer_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mer_ctrl
// Sequencer for the ellipse walk: takes requests, issues step and
// multiply/write-back commands, owns the active flag and result valid.
// ----------------------------------------------------------------------------
module mer_ctrl (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  input  logic             in_mode,
  output logic             in_stall,
  output logic             out_valid,
  input  logic             out_stall,
  input  mer_pkg::status_t status,
  output mer_pkg::cmd_t    cmd
);
  import mer_pkg::*;

  typedef enum logic [11:0] {
    ST_READY = 12'b0000_0000_0001,
    ST_I1A   = 12'b0000_0000_0010,
    ST_I1B   = 12'b0000_0000_0100,
    ST_I1C   = 12'b0000_0000_1000,
    ST_I1D   = 12'b0000_0001_0000,
    ST_I2A   = 12'b0000_0010_0000,
    ST_I2B   = 12'b0000_0100_0000,
    ST_I2C   = 12'b0000_1000_0000,
    ST_I2D   = 12'b0001_0000_0000,
    ST_I2E   = 12'b0010_0000_0000,
    ST_I2F   = 12'b0100_0000_0000,
    ST_QTR   = 12'b1000_0000_0000
  } state_t;

  state_t state_r, state_nxt;
  logic   busy_r, busy_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   in_fire;

  // take a request only when idle and the result slot is free or draining
  assign in_stall = (state_r != ST_READY) || (out_valid_r && out_stall);
  assign in_fire  = in_valid && !in_stall;

  // command decode and next state
  always_comb begin
    state_nxt  = state_r;
    cmd.load   = 1'b0;
    cmd.step   = 1'b0;
    cmd.mul_op = MUL_NONE;
    cmd.wb_op  = WB_NONE;
    case (state_r)
      ST_READY: begin
        if (in_fire && in_mode == MODE_START) begin
          cmd.load  = 1'b1;
          state_nxt = ST_I1A;
        end else if (in_fire && in_mode == MODE_STEP && busy_r) begin
          cmd.step = 1'b1;
          if (status.enter_r2 && !status.last) begin
            state_nxt = ST_I2A;
          end
        end
      end
      // region one start term
      ST_I1A: begin
        cmd.mul_op = MUL_RXRX;
        state_nxt  = ST_I1B;
      end
      ST_I1B: begin
        cmd.mul_op = MUL_RYRY;
        cmd.wb_op  = WB_RX2;
        state_nxt  = ST_I1C;
      end
      ST_I1C: begin
        cmd.mul_op = MUL_RX2RY;
        cmd.wb_op  = WB_RY2;
        state_nxt  = ST_I1D;
      end
      ST_I1D: begin
        cmd.wb_op = WB_INIT1;
        state_nxt = ST_QTR;
      end
      // region two start term
      ST_I2A: begin
        cmd.mul_op = MUL_TXTX;
        state_nxt  = ST_I2B;
      end
      ST_I2B: begin
        cmd.mul_op = MUL_RY2P;
        state_nxt  = ST_I2C;
      end
      ST_I2C: begin
        cmd.mul_op = MUL_YMYM;
        cmd.wb_op  = WB_ACC_SET;
        state_nxt  = ST_I2D;
      end
      ST_I2D: begin
        cmd.mul_op = MUL_RX2P;
        state_nxt  = ST_I2E;
      end
      ST_I2E: begin
        cmd.mul_op = MUL_RX2RY2;
        cmd.wb_op  = WB_ACC_ADD4;
        state_nxt  = ST_I2F;
      end
      ST_I2F: begin
        cmd.wb_op = WB_ACC_SUB4;
        state_nxt = ST_QTR;
      end
      ST_QTR: begin
        cmd.wb_op = WB_QTR;
        state_nxt = ST_READY;
      end
      default: begin
        state_nxt = ST_READY;
      end
    endcase
  end

  // active flag and result valid
  always_comb begin
    busy_nxt = busy_r;
    if (cmd.load) begin
      busy_nxt = 1'b1;
    end else if (cmd.step && status.last) begin
      busy_nxt = 1'b0;
    end
    out_valid_nxt = cmd.step ? 1'b1 : (out_valid_r && out_stall);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_READY;
      busy_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      busy_r      <= busy_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;

  // a new result only follows an accepted step request
  a_result_from_step: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) && $past(rst_n) |-> $past(in_fire && in_mode == MODE_STEP))
    else $error("result raised without a step request");

  // no request taken while a start term is being computed
  a_accept_when_ready: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |-> state_r == ST_READY)
    else $error("request accepted during start-term sequence");

  // the ellipse ends only on a step flagged last
  a_busy_ends_on_last: assert property (@(posedge clk) disable iff (!rst_n)
    $fell(busy_r) && $past(rst_n) |-> $past(cmd.step && status.last) && out_valid_r)
    else $error("ellipse ended without a last point");

endmodule

// ===== rtl/midpoint_ellipse_rasterizer_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// midpoint_ellipse_rasterizer_core
// Two-region midpoint ellipse walker: start requests load the ellipse, step
// requests return the current point mirrored into four quadrants.
// Latency: a result is valid the cycle after its step request is accepted.
// Throughput: one step per cycle inside a region while out_stall is low; the
// step that enters region two holds input through I2A-I2F and QTR (shared
// multiplier sequence). A start request holds input through I1A-I1D and QTR
// (region one start term). Reset: synchronous active-low; clears the
// sequencer, active flag, result valid and region flag. No clearing pass.
// ----------------------------------------------------------------------------
module midpoint_ellipse_rasterizer_core (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  logic                                 in_mode,
  input  logic [mer_pkg::COORD_BITS-1:0]       in_center_x,
  input  logic [mer_pkg::COORD_BITS-1:0]       in_center_y,
  input  logic [mer_pkg::RADIUS_BITS-1:0]      in_radius_x,
  input  logic [mer_pkg::RADIUS_BITS-1:0]      in_radius_y,
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic signed [mer_pkg::OUT_W-1:0]     out_px_right,
  output logic signed [mer_pkg::OUT_W-1:0]     out_px_left,
  output logic signed [mer_pkg::OUT_W-1:0]     out_py_below,
  output logic signed [mer_pkg::OUT_W-1:0]     out_py_above,
  output logic                                 out_last_point
);
  import mer_pkg::*;

  cmd_t    cmd;
  status_t status;

  // sequencer
  mer_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_mode   (in_mode),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .status    (status),
    .cmd       (cmd)
  );

  // walk state, multiplier and result register
  mer_datapath u_datapath (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_center_x    (in_center_x),
    .in_center_y    (in_center_y),
    .in_radius_x    (in_radius_x),
    .in_radius_y    (in_radius_y),
    .cmd            (cmd),
    .status         (status),
    .out_px_right   (out_px_right),
    .out_px_left    (out_px_left),
    .out_py_below   (out_py_below),
    .out_py_above   (out_py_above),
    .out_last_point (out_last_point)
  );

endmodule
